// File: rtl/core/ohs_pkg.sv
// Shared types and constants for the open-addressing hash set.
`default_nettype none

package ohs_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_ABSENT  = 2'd1,
        STAT_PRESENT = 2'd2,
        STAT_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_ACTIVE  = 2'd1,
        MARK_DELETED = 2'd2
    } t_mark;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_DIV,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    localparam logic CFG_PROBE_MODE = 1'b0;
    localparam logic CFG_TABLE_SIZE = 1'b1;

    localparam logic [7:0] DEF_TABLE_SIZE = 8'd103;
    localparam logic [7:0] MIN_TABLE_SIZE = 8'd3;
    localparam logic [8:0] QUAD_INC       = 9'd2;

endpackage

`default_nettype wire

// File: rtl/core/ohs_store.sv
// Slot key and slot mark memories with registered read data.
`default_nettype none

module ohs_store
    import ohs_pkg::*;
#(
    parameter int CAP = 128,
    parameter int SW  = 32,
    parameter int AW  = 7
) (
    input  wire logic          i_clk,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_mark              o_rd_mark,
    output logic      [SW-1:0] o_rd_key,
    input  wire logic          i_key_we,
    input  wire logic          i_mark_we,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [SW-1:0] i_wr_key,
    input  wire t_mark         i_wr_mark
);

    logic  [SW-1:0] r_key_mem [CAP];
    t_mark          r_mark_mem [CAP];
    logic  [SW-1:0] r_rd_key;
    t_mark          r_rd_mark;

    always_ff @(posedge i_clk) begin
        if (i_key_we) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
        end
        r_rd_key <= r_key_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_mark_we) begin
            r_mark_mem[i_wr_addr] <= i_wr_mark;
        end
        r_rd_mark <= r_mark_mem[i_rd_addr];
    end

    assign o_rd_key  = r_rd_key;
    assign o_rd_mark = r_rd_mark;

endmodule

`default_nettype wire

// File: rtl/core/open_addressing_hash_set.sv
// Insert/remove/lookup reduce the key modulo the table size to a home slot
// (one remainder bit per cycle), read and check probed slots, then hand off.
// Clear empties all TABLE_CAPACITY mark rows, one mark row cleared per cycle.
// One transaction in flight; o_in_stall is high until the result is staged.
// Reset is synchronous; after reset a sweep empties all marks before the first
// transaction is taken (config writes still accepted).
`default_nettype none

module open_addressing_hash_set
    import ohs_pkg::*;
#(
    parameter int TABLE_CAPACITY = 128,
    parameter int KEY_WIDTH      = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_key,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_success,
    output logic [1:0]       o_status,
    output logic [6:0]       o_slot
);

    localparam int AW       = $clog2(TABLE_CAPACITY);
    localparam int SW       = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    localparam int BW       = $clog2(SW);
    localparam int CAP_CLIP = (TABLE_CAPACITY > 255) ? 255 : TABLE_CAPACITY;

    t_state         r_state, n_state;
    logic           r_probe_mode, n_probe_mode;
    logic [7:0]     r_size, n_size;
    logic [7:0]     r_count, n_count;
    logic [AW-1:0]  r_sweep, n_sweep;
    logic           r_sweep_reply, n_sweep_reply;
    logic           r_out_valid, n_out_valid;

    t_action        r_action, n_action;
    logic [SW-1:0]  r_key, n_key;
    logic [7:0]     r_rem, n_rem;
    logic [BW-1:0]  r_bit, n_bit;
    logic [7:0]     r_pos, n_pos;
    logic [7:0]     r_inc, n_inc;
    logic [7:0]     r_steps, n_steps;
    logic           r_res_success, n_res_success;
    t_status        r_res_status, n_res_status;
    logic [6:0]     r_res_slot, n_res_slot;
    logic           r_out_success, n_out_success;
    t_status        r_out_status, n_out_status;
    logic [6:0]     r_out_slot, n_out_slot;

    logic [7:0]     w_eff;
    logic [8:0]     w_unit_a;
    logic [7:0]     w_unit_y;
    logic           w_accept;
    logic           w_out_free;
    logic           w_sweep_end;
    t_mark          w_rd_mark;
    logic [SW-1:0]  w_rd_key;
    logic           w_hit;
    logic           w_found;
    logic           w_last;
    logic           w_finish;
    logic           w_over;
    logic           w_do_insert;
    logic           w_do_remove;
    logic [AW+7:0]  w_pos_ext;
    logic [AW-1:0]  w_pos_addr;
    logic           w_key_we;
    logic           w_mark_we;
    logic [AW-1:0]  w_wr_addr;
    t_mark          w_wr_mark;

    assign w_eff = (r_size < MIN_TABLE_SIZE) ? MIN_TABLE_SIZE :
                   ((r_size > 8'(CAP_CLIP)) ? 8'(CAP_CLIP) : r_size);

    // shared conditional-subtract unit: operand is always below twice the size
    always_comb begin
        case (r_state)
            S_DIV:   w_unit_a = {r_rem, r_key[r_bit]};
            S_CHECK: w_unit_a = {1'b0, r_pos} + {1'b0, r_inc};
            S_READ:  w_unit_a = {1'b0, r_inc} + QUAD_INC;
            default: w_unit_a = '0;
        endcase
    end

    assign w_unit_y = (w_unit_a >= {1'b0, w_eff}) ? 8'(w_unit_a - {1'b0, w_eff})
                                                   : w_unit_a[7:0];

    assign w_accept    = (r_state == S_IDLE) && i_in_valid;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_sweep_end = (r_sweep == AW'(TABLE_CAPACITY - 1));

    assign w_pos_ext  = {{AW{1'b0}}, r_pos};
    assign w_pos_addr = w_pos_ext[AW-1:0];

    assign w_hit       = (w_rd_mark == MARK_EMPTY) || (w_rd_key == r_key);
    assign w_found     = w_hit && (w_rd_mark == MARK_ACTIVE);
    assign w_last      = (r_steps == (w_eff - 8'd1));
    assign w_finish    = w_hit || w_last;
    assign w_over      = ({1'b0, r_count} + 9'd1) > {2'b00, w_eff[7:1]};
    assign w_do_insert = (r_action == ACT_INSERT) && w_hit && !w_found && !w_over;
    assign w_do_remove = (r_action == ACT_REMOVE) && w_found;

    ohs_store #(
        .CAP (TABLE_CAPACITY),
        .SW  (SW),
        .AW  (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_addr (w_pos_addr),
        .o_rd_mark (w_rd_mark),
        .o_rd_key  (w_rd_key),
        .i_key_we  (w_key_we),
        .i_mark_we (w_mark_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_key  (r_key),
        .i_wr_mark (w_wr_mark)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_SWEEP: begin
                if (w_sweep_end) begin
                    n_state = r_sweep_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (t_action'(i_action) == ACT_CLEAR) ? S_SWEEP : S_DIV;
                end
            end
            S_DIV: begin
                if (r_bit == '0) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_CHECK;
            S_CHECK: n_state = w_finish ? S_DONE : S_READ;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_SWEEP;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_key_we   = (r_state == S_CHECK) && w_do_insert;
        w_mark_we  = (r_state == S_SWEEP) ||
                     ((r_state == S_CHECK) && (w_do_insert || w_do_remove));
        w_wr_addr  = (r_state == S_SWEEP) ? r_sweep : w_pos_addr;
        if (r_state == S_SWEEP) begin
            w_wr_mark = MARK_EMPTY;
        end else if (r_action == ACT_INSERT) begin
            w_wr_mark = MARK_ACTIVE;
        end else begin
            w_wr_mark = MARK_DELETED;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_success   = r_out_success;
    assign o_status    = r_out_status;
    assign o_slot      = r_out_slot;

    // datapath
    always_comb begin
        n_probe_mode  = r_probe_mode;
        n_size        = r_size;
        n_count       = r_count;
        n_sweep       = r_sweep;
        n_sweep_reply = r_sweep_reply;
        n_out_valid   = r_out_valid;
        n_action      = r_action;
        n_key         = r_key;
        n_rem         = r_rem;
        n_bit         = r_bit;
        n_pos         = r_pos;
        n_inc         = r_inc;
        n_steps       = r_steps;
        n_res_success = r_res_success;
        n_res_status  = r_res_status;
        n_res_slot    = r_res_slot;
        n_out_success = r_out_success;
        n_out_status  = r_out_status;
        n_out_slot    = r_out_slot;

        if (i_cfg_we) begin
            if (i_cfg_index == CFG_PROBE_MODE) begin
                n_probe_mode = i_cfg_data[0];
            end else begin
                n_size = i_cfg_data;
            end
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_SWEEP: begin
                n_sweep = r_sweep + AW'(1);
                if (w_sweep_end) begin
                    n_sweep_reply = 1'b0;
                    n_res_success = 1'b1;
                    n_res_status  = STAT_OK;
                    n_res_slot    = '0;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_action = t_action'(i_action);
                    n_key    = i_key[SW-1:0];
                    n_rem    = '0;
                    n_bit    = BW'(SW - 1);
                    if (t_action'(i_action) == ACT_CLEAR) begin
                        n_count       = '0;
                        n_sweep       = '0;
                        n_sweep_reply = 1'b1;
                    end
                end
            end
            S_DIV: begin
                n_rem = w_unit_y;
                n_bit = r_bit - BW'(1);
                if (r_bit == '0) begin
                    n_pos   = w_unit_y;
                    n_steps = '0;
                    n_inc   = 8'd1;
                end
            end
            S_READ: begin
                if (r_probe_mode && (r_steps != '0)) begin
                    n_inc = w_unit_y;
                end
            end
            S_CHECK: begin
                if (w_finish) begin
                    n_res_success = 1'b0;
                    n_res_status  = STAT_ABSENT;
                    n_res_slot    = '0;
                    case (r_action)
                        ACT_INSERT: begin
                            if (w_found) begin
                                n_res_status = STAT_PRESENT;
                                n_res_slot   = r_pos[6:0];
                            end else if (!w_hit || w_over) begin
                                n_res_status = STAT_FULL;
                            end else begin
                                n_count       = r_count + 8'd1;
                                n_res_success = 1'b1;
                                n_res_status  = STAT_OK;
                                n_res_slot    = r_pos[6:0];
                            end
                        end
                        ACT_REMOVE, ACT_LOOKUP: begin
                            if (w_found) begin
                                n_res_success = 1'b1;
                                n_res_status  = STAT_OK;
                                n_res_slot    = r_pos[6:0];
                            end
                        end
                        default: begin
                            n_res_status = STAT_ABSENT;
                        end
                    endcase
                end else begin
                    n_pos   = w_unit_y;
                    n_steps = r_steps + 8'd1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_success = r_res_success;
                    n_out_status  = r_res_status;
                    n_out_slot    = r_res_slot;
                end
            end
            default: begin
                n_sweep = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_SWEEP;
            r_probe_mode  <= 1'b0;
            r_size        <= DEF_TABLE_SIZE;
            r_count       <= '0;
            r_sweep       <= '0;
            r_sweep_reply <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_probe_mode  <= n_probe_mode;
            r_size        <= n_size;
            r_count       <= n_count;
            r_sweep       <= n_sweep;
            r_sweep_reply <= n_sweep_reply;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action      <= n_action;
        r_key         <= n_key;
        r_rem         <= n_rem;
        r_bit         <= n_bit;
        r_pos         <= n_pos;
        r_inc         <= n_inc;
        r_steps       <= n_steps;
        r_res_success <= n_res_success;
        r_res_status  <= n_res_status;
        r_res_slot    <= n_res_slot;
        r_out_success <= n_out_success;
        r_out_status  <= n_out_status;
        r_out_slot    <= n_out_slot;
    end

endmodule

`default_nettype wire
